// ===== src/pts_pkg.sv =====
// shared types and constants for the point to segment/ray/line distance block
// no dependencies
package pts_pkg;

	localparam int COORD_BITS    = 16;
	localparam int OUT_FRAC_BITS = 8;

	// derived widths
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int FRAC2   = 2 * OUT_FRAC_BITS;
	localparam int Q_W     = PROD_W + FRAC2;
	localparam int NUM_W   = Q_W + PROD_W + 1;
	localparam int DSH_W   = PROD_W + Q_W - 1;
	localparam int RAD_W   = Q_W;
	localparam int DIST_W  = Q_W / 2;
	localparam int HALF_W  = PROD_W / 2;

	typedef enum logic [1:0] {
		MODE_POINT,
		MODE_SEG,
		MODE_RAY,
		MODE_LINE
	} pts_mode_t;

	// control that travels beside the payload through the cell chains
	typedef struct packed {
		logic valid;
		logic degen;
	} pts_ctl_t;

endpackage

// ===== src/pts_div_cell.sv =====
// one restoring divider cell: produces one quotient bit per item
// depends on pts_pkg
module pts_div_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pts_pkg::pts_ctl_t          ctl_i,
	input  logic [pts_pkg::NUM_W-1:0]  rem_i,
	input  logic [pts_pkg::DSH_W-1:0]  dsh_i,
	input  logic [pts_pkg::Q_W-1:0]    q_i,
	output pts_pkg::pts_ctl_t          ctl_o,
	output logic [pts_pkg::NUM_W-1:0]  rem_o,
	output logic [pts_pkg::DSH_W-1:0]  dsh_o,
	output logic [pts_pkg::Q_W-1:0]    q_o
);
	import pts_pkg::*;

	logic             ge;
	logic [NUM_W-1:0] dwide;

	// trial subtract of the shifted divisor
	assign dwide = NUM_W'(dsh_i);
	assign ge    = (rem_i >= dwide);

	// control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_i;
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		rem_o <= ge ? (rem_i - dwide) : rem_i;
		dsh_o <= dsh_i >> 1;
		q_o   <= {q_i[Q_W-2:0], ge};
	end

endmodule

// ===== src/pts_sqrt_cell.sv =====
// one square root cell: settles one root bit per item
// depends on pts_pkg
module pts_sqrt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pts_pkg::pts_ctl_t          ctl_i,
	input  logic [pts_pkg::RAD_W-1:0]  rem_i,
	input  logic [pts_pkg::RAD_W-1:0]  res_i,
	input  logic [pts_pkg::RAD_W-1:0]  bit_i,
	output pts_pkg::pts_ctl_t          ctl_o,
	output logic [pts_pkg::RAD_W-1:0]  rem_o,
	output logic [pts_pkg::RAD_W-1:0]  res_o,
	output logic [pts_pkg::RAD_W-1:0]  bit_o
);
	import pts_pkg::*;

	logic [RAD_W:0] trial;
	logic           ge;

	// trial value res + bit against the remainder
	assign trial = (RAD_W+1)'(res_i) + (RAD_W+1)'(bit_i);
	assign ge    = ({1'b0, rem_i} >= trial);

	// control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_i;
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		rem_o <= ge ? (rem_i - trial[RAD_W-1:0]) : rem_i;
		res_o <= ge ? ((res_i >> 1) + bit_i) : (res_i >> 1);
		bit_o <= bit_i >> 2;
	end

endmodule

// ===== src/point_to_segment_ray_line_distance.sv =====
// distance from P to point A, segment AB, ray AB or line AB
// pipeline: 5 front stages, then Q_W divider cells, then DIST_W root cells
// throughput: one item per cycle, busy stays low; the result strobe cannot be held off
// reset clears only the control bits (valid and degen) of the pipeline; nothing else is kept between items
// depends on pts_pkg, pts_div_cell, pts_sqrt_cell
module point_to_segment_ray_line_distance (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          mode,
	input  logic signed [pts_pkg::COORD_BITS-1:0] px,
	input  logic signed [pts_pkg::COORD_BITS-1:0] py,
	input  logic signed [pts_pkg::COORD_BITS-1:0] ax,
	input  logic signed [pts_pkg::COORD_BITS-1:0] ay,
	input  logic signed [pts_pkg::COORD_BITS-1:0] bx,
	input  logic signed [pts_pkg::COORD_BITS-1:0] by_coord,
	output logic                                done,
	output logic [pts_pkg::DIST_W-1:0]          distance,
	output logic                                degenerate
);
	import pts_pkg::*;

	// stage 1: differences
	logic                     v_s1;
	pts_mode_t                mode_s1;
	logic signed [DIFF_W-1:0] abx_s1, aby_s1, apx_s1, apy_s1, bpx_s1, bpy_s1;

	// stage 2: products
	logic                     v_s2;
	pts_mode_t                mode_s2;
	logic signed [PROD_W-1:0] pd1_s2, pd2_s2, pc1_s2, pc2_s2;
	logic [PROD_W-1:0]        abx2_s2, aby2_s2, apx2_s2, apy2_s2, bpx2_s2, bpy2_s2;
	logic signed [PROD_W-1:0] m_pd1, m_pd2, m_pc1, m_pc2;
	logic signed [PROD_W-1:0] m_abx2, m_aby2, m_apx2, m_apy2, m_bpx2, m_bpy2;

	// stage 3: sums
	logic                     v_s3;
	pts_mode_t                mode_s3;
	logic signed [SUM_W-1:0]  dot_s3, cr_s3;
	logic [PROD_W-1:0]        l2_s3, la2_s3, lb2_s3;

	// stage 4: decision and partial squares of the cross product
	logic                     v_s4, perp_s4, degen_s4;
	logic [PROD_W-1:0]        l2_s4, lsel_s4;
	logic [PROD_W+HALF_W-1:0] ph_s4, pl_s4;
	logic signed [SUM_W-1:0]  cr_neg;
	logic [PROD_W-1:0]        crabs;
	logic                     dpos, in_seg, perp_c;

	// stage 5: numerator and denominator
	pts_ctl_t                 ctl_s5;
	logic [NUM_W-1:0]         num_s5;
	logic [PROD_W-1:0]        den_s5;
	logic [2*PROD_W-1:0]      sq_c;

	// cell chains
	pts_ctl_t         dctl [0:Q_W];
	logic [NUM_W-1:0] drem [0:Q_W];
	logic [DSH_W-1:0] ddsh [0:Q_W];
	logic [Q_W-1:0]   dq   [0:Q_W];
	pts_ctl_t         sctl [0:DIST_W];
	logic [RAD_W-1:0] srem [0:DIST_W];
	logic [RAD_W-1:0] sres [0:DIST_W];
	logic [RAD_W-1:0] sbit [0:DIST_W];

	assign busy = 1'b0;

	// valid bits of the front stages, and the control of stage 5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			ctl_s5 <= '0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			ctl_s5 <= '{valid: v_s4, degen: degen_s4};
		end
	end

	// products of the differences
	always_comb begin
		m_pd1  = abx_s1 * apx_s1;
		m_pd2  = aby_s1 * apy_s1;
		m_pc1  = abx_s1 * apy_s1;
		m_pc2  = aby_s1 * apx_s1;
		m_abx2 = abx_s1 * abx_s1;
		m_aby2 = aby_s1 * aby_s1;
		m_apx2 = apx_s1 * apx_s1;
		m_apy2 = apy_s1 * apy_s1;
		m_bpx2 = bpx_s1 * bpx_s1;
		m_bpy2 = bpy_s1 * bpy_s1;
	end

	// mode decision and absolute cross product
	always_comb begin
		cr_neg = -cr_s3;
		crabs  = cr_s3[SUM_W-1] ? cr_neg[PROD_W-1:0] : cr_s3[PROD_W-1:0];
		dpos   = !dot_s3[SUM_W-1] && (dot_s3 != '0);
		in_seg = dpos && (dot_s3 < $signed({1'b0, l2_s3}));
		case (mode_s3)
			MODE_SEG:  perp_c = in_seg;
			MODE_RAY:  perp_c = dpos;
			MODE_LINE: perp_c = (l2_s3 != '0);
			default:   perp_c = 1'b0;
		endcase
	end

	// high partial square of the cross product, shifted into place
	assign sq_c = (2*PROD_W)'(ph_s4) << HALF_W;

	// front pipeline payload
	always_ff @(posedge clk) begin
		mode_s1 <= pts_mode_t'(mode);
		abx_s1  <= DIFF_W'(bx) - DIFF_W'(ax);
		aby_s1  <= DIFF_W'(by_coord) - DIFF_W'(ay);
		apx_s1  <= DIFF_W'(px) - DIFF_W'(ax);
		apy_s1  <= DIFF_W'(py) - DIFF_W'(ay);
		bpx_s1  <= DIFF_W'(px) - DIFF_W'(bx);
		bpy_s1  <= DIFF_W'(py) - DIFF_W'(by_coord);

		mode_s2 <= mode_s1;
		pd1_s2  <= m_pd1;
		pd2_s2  <= m_pd2;
		pc1_s2  <= m_pc1;
		pc2_s2  <= m_pc2;
		abx2_s2 <= $unsigned(m_abx2);
		aby2_s2 <= $unsigned(m_aby2);
		apx2_s2 <= $unsigned(m_apx2);
		apy2_s2 <= $unsigned(m_apy2);
		bpx2_s2 <= $unsigned(m_bpx2);
		bpy2_s2 <= $unsigned(m_bpy2);

		mode_s3 <= mode_s2;
		dot_s3  <= SUM_W'(pd1_s2) + SUM_W'(pd2_s2);
		cr_s3   <= SUM_W'(pc1_s2) - SUM_W'(pc2_s2);
		l2_s3   <= abx2_s2 + aby2_s2;
		la2_s3  <= apx2_s2 + apy2_s2;
		lb2_s3  <= bpx2_s2 + bpy2_s2;

		perp_s4  <= perp_c;
		degen_s4 <= (mode_s3 == MODE_LINE) && (l2_s3 == '0);
		l2_s4    <= l2_s3;
		lsel_s4  <= ((mode_s3 == MODE_SEG) && (lb2_s3 < la2_s3)) ? lb2_s3 : la2_s3;
		ph_s4    <= crabs * crabs[PROD_W-1:HALF_W];
		pl_s4    <= crabs * crabs[HALF_W-1:0];

		if (perp_s4) begin
			num_s5 <= NUM_W'({sq_c + (2*PROD_W)'(pl_s4), {FRAC2{1'b0}}});
			den_s5 <= l2_s4;
		end else if (degen_s4) begin
			num_s5 <= '0;
			den_s5 <= PROD_W'(1);
		end else begin
			num_s5 <= NUM_W'({lsel_s4, {FRAC2{1'b0}}});
			den_s5 <= PROD_W'(1);
		end
	end

	// divider chain
	assign dctl[0] = ctl_s5;
	assign drem[0] = num_s5;
	assign ddsh[0] = {den_s5, {(Q_W-1){1'b0}}};
	assign dq[0]   = '0;

	for (genvar i = 0; i < Q_W; i++) begin : g_div
		pts_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (dctl[i]),
			.rem_i  (drem[i]),
			.dsh_i  (ddsh[i]),
			.q_i    (dq[i]),
			.ctl_o  (dctl[i+1]),
			.rem_o  (drem[i+1]),
			.dsh_o  (ddsh[i+1]),
			.q_o    (dq[i+1])
		);
	end

	// square root chain
	assign sctl[0] = dctl[Q_W];
	assign srem[0] = dq[Q_W];
	assign sres[0] = '0;
	assign sbit[0] = RAD_W'(1) << (RAD_W - 2);

	for (genvar j = 0; j < DIST_W; j++) begin : g_sqrt
		pts_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (sctl[j]),
			.rem_i  (srem[j]),
			.res_i  (sres[j]),
			.bit_i  (sbit[j]),
			.ctl_o  (sctl[j+1]),
			.rem_o  (srem[j+1]),
			.res_o  (sres[j+1]),
			.bit_o  (sbit[j+1])
		);
	end

	// result ports
	assign done       = sctl[DIST_W].valid;
	assign degenerate = sctl[DIST_W].degen;
	assign distance   = sres[DIST_W][DIST_W-1:0];

	// checks
	a_no_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s5.valid |-> (den_s5 != '0))
		else $error("zero divisor entered the divider chain");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (distance == '0))
		else $error("degenerate line with nonzero distance");

	a_accept_flow: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> v_s1)
		else $error("accepted item did not enter the pipeline");

endmodule
